[design/plps_pkg.sv]
// Shared types, constants and helpers of the pairwise Legendre power spectrum block.
package plps_pkg;

	localparam int PARTICLE_DEPTH_DEF = 256;
	localparam int DEGREE_DEPTH_DEF   = 64;
	localparam logic [6:0] DEGREE_LIMIT_RESET = 7'd16;

	// Divider geometry: quotients below 2^30, dividends below 2^38.
	localparam int DIV_QW = 30;
	localparam int DIV_NW = 38;

	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

	localparam logic [2:0] ACT_LOAD_LEFT   = 3'd0;
	localparam logic [2:0] ACT_LOAD_RIGHT  = 3'd1;
	localparam logic [2:0] ACT_COEFF_LEFT  = 3'd2;
	localparam logic [2:0] ACT_COEFF_RIGHT = 3'd3;
	localparam logic [2:0] ACT_COMPUTE     = 3'd4;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [15:0]        weight;
		logic [7:0]         slot;
		logic signed [15:0] coeff;
		logic [8:0]         left_count;
		logic [8:0]         right_count;
	} request_t;

	typedef struct packed {
		logic [6:0]         degree;
		logic signed [63:0] power;
		logic               last;
	} result_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CLEAR, S_PREAD, S_DOT1, S_DOT2,
		S_RMUL, S_RRND, S_RNUM, S_RPREP, S_RDIV,
		S_TMUL, S_TRND, S_TACC,
		S_ORD, S_OMULC, S_OABS, S_OLO, S_OHI, S_OSUM, S_OWAIT
	} state_t;

	// Arithmetic shift right with rounding half away from zero.
	function automatic logic signed [63:0] round_shr(input logic signed [63:0] v,
			input int unsigned sh);
		logic signed [63:0] bias;
		bias = (64'sd1 <<< (sh - 1)) - $signed({63'd0, v[63]});
		return (v + bias) >>> sh;
	endfunction

endpackage

[design/plps_channels.sv]
// Valid/ready channel interfaces for requests and results.
interface plps_request_if;
	import plps_pkg::*;
	logic     valid;
	logic     ready;
	request_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface plps_result_if;
	import plps_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[design/plps_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module plps_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [plps_pkg::DIV_NW-1:0] dividend,
	input  logic [6:0]                  divisor,
	output logic                        done,
	output logic [plps_pkg::DIV_QW-1:0] quotient
);
	import plps_pkg::*;

	localparam int CW = $clog2(DIV_QW + 1);

	logic [6:0]        rem_q;
	logic [DIV_QW-1:0] low_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [7:0]        trial;
	logic              qbit;

	assign trial = {rem_q, low_q[DIV_QW-1]};
	assign qbit  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// The caller guarantees the quotient fits, so the top bits start below the divisor.
			rem_q <= dividend[DIV_QW+6:DIV_QW];
			low_q <= dividend[DIV_QW-1:0];
		end else if (busy_q) begin
			rem_q <= qbit ? 7'(trial - {1'b0, divisor}) : trial[6:0];
			low_q <= {low_q[DIV_QW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = low_q;
endmodule

[design/pairwise_legendre_power_spectrum.sv]
// Top level of the pairwise Legendre power spectrum block.
// Requests load left and right particles (Q1.15 direction, Q0.16 weight) and per-degree
// coefficients into on-chip memories, one request per cycle. A compute request first clears
// the per-degree sums up to the saturated degree_limit, then walks every left-right pair,
// left index outer. Each pair reads its two particles and forms the dot product and degree
// 1; each further degree runs a Bonnet recursion step that the serial divider finishes, one
// quotient bit per cycle, unless the step clamps. Each degree ends with a read-modify-write
// of the sum memory. Results are then produced one degree at a time, each held until the
// result channel takes it; the last carries last = 1. No requests are taken while a compute
// is running. The user must write degree_limit through cfg_write/cfg_data only while the
// block is idle; the block itself leaves this unchecked.
module pairwise_legendre_power_spectrum #(
	parameter int PARTICLE_DEPTH = plps_pkg::PARTICLE_DEPTH_DEF,
	parameter int DEGREE_DEPTH   = plps_pkg::DEGREE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [6:0]           cfg_data,
	plps_request_if.sink         requests,
	plps_result_if.source        results
);
	import plps_pkg::*;

	localparam int PAW = (PARTICLE_DEPTH > 1) ? $clog2(PARTICLE_DEPTH) : 1;
	localparam int DAW = (DEGREE_DEPTH > 1) ? $clog2(DEGREE_DEPTH) : 1;
	localparam int PCW = $clog2(PARTICLE_DEPTH + 1);

	// The four particle and coefficient stores hold whatever was loaded.
	logic [63:0]        lmem [PARTICLE_DEPTH];
	logic [63:0]        rmem [PARTICLE_DEPTH];
	logic [15:0]        lcm  [DEGREE_DEPTH];
	logic [15:0]        rcm  [DEGREE_DEPTH];
	logic signed [63:0] smem [DEGREE_DEPTH];

	state_t state_q, state_d;

	logic [6:0]     limit_q;
	logic [6:0]     lmax_q;
	logic [6:0]     deg_q;
	logic [PCW-1:0] nl_q, nr_q, pi_q, pj_q;

	logic [63:0]        lrd_s1, rrd_s1;
	logic [15:0]        lcrd_s1, rcrd_s1;
	logic signed [63:0] srd_s1;

	// Pair datapath registers.
	logic signed [31:0] mx_q, my_q, mz_q;
	logic [31:0]        fprod_q;
	logic signed [31:0] cz_q, p_cur_q, p_prev_q, r_q;
	logic signed [63:0] prod_q, tprod_q, term_q;
	logic signed [40:0] num_q;
	logic               rneg_q;

	// Output datapath registers.
	logic signed [63:0] s_q;
	logic signed [31:0] c_q;
	logic [63:0]        a_q;
	logic [30:0]        b_q;
	logic               oneg_q;
	logic [62:0]        plo_q, phi_q;
	logic               out_valid_q;
	result_t            out_q;

	logic req_fire, res_fire;
	logic slot_p_ok, slot_d_ok;
	logic [PAW-1:0] slot_p;
	logic [DAW-1:0] slot_d, saddr;
	logic [6:0] lmax_w;
	logic [PCW-1:0] nl_w, nr_w;
	logic pair_last_j, pair_last_i, deg_last;

	// The divider is the long pole in each recursion step.
	logic        div_start, div_done;
	logic [DIV_NW-1:0] div_n;
	logic [DIV_QW-1:0] div_q;

	assign req_fire = requests.valid && requests.ready;
	assign res_fire = results.valid && results.ready;

	assign slot_p_ok = 32'(requests.data.slot) < PARTICLE_DEPTH;
	assign slot_d_ok = 32'(requests.data.slot) < DEGREE_DEPTH;
	assign slot_p    = PAW'(requests.data.slot);
	assign slot_d    = DAW'(requests.data.slot);
	assign saddr     = DAW'(deg_q - 7'd1);

	// Degree limit and counts above the store depths are saturated.
	assign lmax_w = (32'(limit_q) > DEGREE_DEPTH) ? 7'(DEGREE_DEPTH) : limit_q;
	assign nl_w = (32'(requests.data.left_count) > PARTICLE_DEPTH) ?
		PCW'(PARTICLE_DEPTH) : PCW'(requests.data.left_count);
	assign nr_w = (32'(requests.data.right_count) > PARTICLE_DEPTH) ?
		PCW'(PARTICLE_DEPTH) : PCW'(requests.data.right_count);

	assign pair_last_j = PCW'(pj_q + 1'b1) == nr_q;
	assign pair_last_i = PCW'(pi_q + 1'b1) == nl_q;
	assign deg_last    = deg_q == lmax_q;

	// Combinational arithmetic, each feeding one register.
	logic signed [31:0] mx_w, my_w, mz_w, c_w;
	logic [31:0]        fprod_w;
	logic signed [33:0] dot_w;
	logic signed [31:0] cz_w;
	logic signed [63:0] prod_w;
	logic signed [63:0] rrnd_w;
	logic signed [64:0] tprod_w;
	logic [7:0]         k1;
	logic [6:0]         k2;
	logic signed [40:0] num_w, mag_w;
	logic [DIV_NW-1:0]  n_w;
	logic               clamp_w;
	logic signed [64:0] sum_w;
	logic signed [63:0] sat_w;
	logic [62:0]        plo_w, phi_w;
	logic [64:0]        lo_rnd, osum_w;
	logic signed [63:0] power_w;
	logic signed [31:0] pdiv_w;

	assign mx_w    = $signed(lrd_s1[63:48]) * $signed(rrd_s1[63:48]);
	assign my_w    = $signed(lrd_s1[47:32]) * $signed(rrd_s1[47:32]);
	assign mz_w    = $signed(lrd_s1[31:16]) * $signed(rrd_s1[31:16]);
	assign fprod_w = lrd_s1[15:0] * rrd_s1[15:0];
	assign dot_w   = mx_q + my_q + mz_q;
	assign cz_w    = (dot_w > 34'(ONE_Q30)) ? ONE_Q30 :
		(dot_w < -34'(ONE_Q30)) ? -ONE_Q30 : dot_w[31:0];

	assign prod_w  = cz_q * p_cur_q;
	assign rrnd_w  = round_shr(prod_q, 30);
	assign tprod_w = $signed({1'b0, fprod_q}) * p_cur_q;

	// Bonnet numerator (2l-1)*r - (l-1)*P_{l-2}, then magnitude plus half the divisor.
	assign k1      = {deg_q, 1'b0} - 8'd1;
	assign k2      = deg_q - 7'd1;
	assign num_w   = 41'(r_q) * $signed({33'd0, k1}) - 41'(p_prev_q) * $signed({34'd0, k2});
	assign mag_w   = num_q[40] ? -num_q : num_q;
	assign n_w     = mag_w[DIV_NW-1:0] + DIV_NW'(deg_q[6:1]);
	// A quotient of 2^30 or more clamps, so the divider never has to produce it.
	assign clamp_w = n_w >= DIV_NW'({deg_q, 30'd0});
	assign pdiv_w  = rneg_q ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});

	assign sum_w = {srd_s1[63], srd_s1} + {term_q[63], term_q};
	assign sat_w = (sum_w[64] != sum_w[63]) ?
		(sum_w[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum_w[63:0];

	assign c_w    = $signed(lcrd_s1) * $signed(rcrd_s1);
	assign plo_w  = a_q[31:0] * b_q;
	assign phi_w  = a_q[63:32] * b_q;
	assign lo_rnd = ({2'b00, plo_q} + 65'd536870912) >> 30;
	assign osum_w = {phi_q, 2'b00} + lo_rnd;
	always_comb begin
		if (oneg_q) begin
			power_w = (osum_w[64:63] != 2'b00) ? {1'b1, 63'd0} : -$signed(osum_w[63:0]);
		end else begin
			power_w = (osum_w[64:63] != 2'b00) ? {1'b0, {63{1'b1}}} : osum_w[63:0];
		end
	end

	assign div_n = n_w;

	plps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (deg_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= DEGREE_LIMIT_RESET;
		end else if (cfg_write) begin
			limit_q <= cfg_data;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		requests.ready = 1'b0;
		div_start      = 1'b0;
		case (state_q)
			S_IDLE: begin
				requests.ready = 1'b1;
				if (req_fire && requests.data.action == ACT_COMPUTE && lmax_w != 7'd0) begin
					state_d = S_CLEAR;
				end
			end
			S_CLEAR: begin
				if (deg_last) begin
					state_d = (nl_q == '0 || nr_q == '0) ? S_ORD : S_PREAD;
				end
			end
			S_PREAD: state_d = S_DOT1;
			S_DOT1:  state_d = S_DOT2;
			S_DOT2:  state_d = S_TMUL;
			S_RMUL:  state_d = S_RRND;
			S_RRND:  state_d = S_RNUM;
			S_RNUM:  state_d = S_RPREP;
			S_RPREP: begin
				if (clamp_w) begin
					state_d = S_TMUL;
				end else begin
					div_start = 1'b1;
					state_d   = S_RDIV;
				end
			end
			S_RDIV: begin
				if (div_done) begin
					state_d = S_TMUL;
				end
			end
			S_TMUL: state_d = S_TRND;
			S_TRND: state_d = S_TACC;
			S_TACC: begin
				if (!deg_last) begin
					state_d = S_RMUL;
				end else if (pair_last_j && pair_last_i) begin
					state_d = S_ORD;
				end else begin
					state_d = S_PREAD;
				end
			end
			S_ORD:   state_d = S_OMULC;
			S_OMULC: state_d = S_OABS;
			S_OABS:  state_d = S_OLO;
			S_OLO:   state_d = S_OHI;
			S_OHI:   state_d = S_OSUM;
			S_OSUM:  state_d = S_OWAIT;
			S_OWAIT: begin
				if (res_fire) begin
					state_d = deg_last ? S_IDLE : S_ORD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Counters and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q       <= 7'd1;
			lmax_q      <= 7'd0;
			nl_q        <= '0;
			nr_q        <= '0;
			pi_q        <= '0;
			pj_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire && requests.data.action == ACT_COMPUTE) begin
						lmax_q <= lmax_w;
						nl_q   <= nl_w;
						nr_q   <= nr_w;
						deg_q  <= 7'd1;
					end
				end
				S_CLEAR: begin
					if (deg_last) begin
						deg_q <= 7'd1;
						pi_q  <= '0;
						pj_q  <= '0;
					end else begin
						deg_q <= deg_q + 7'd1;
					end
				end
				S_DOT2: deg_q <= 7'd1;
				S_TACC: begin
					if (!deg_last) begin
						deg_q <= deg_q + 7'd1;
					end else begin
						deg_q <= 7'd1;
						if (pair_last_j) begin
							pj_q <= '0;
							pi_q <= PCW'(pi_q + 1'b1);
						end else begin
							pj_q <= PCW'(pj_q + 1'b1);
						end
					end
				end
				S_OSUM: out_valid_q <= 1'b1;
				S_OWAIT: begin
					if (res_fire) begin
						out_valid_q <= 1'b0;
						if (!deg_last) begin
							deg_q <= deg_q + 7'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_DOT1: begin
				mx_q    <= mx_w;
				my_q    <= my_w;
				mz_q    <= mz_w;
				fprod_q <= fprod_w;
			end
			S_DOT2: begin
				cz_q     <= cz_w;
				p_cur_q  <= cz_w;
				p_prev_q <= ONE_Q30;
			end
			S_RMUL:  prod_q <= prod_w;
			S_RRND:  r_q    <= rrnd_w[31:0];
			S_RNUM:  num_q  <= num_w;
			S_RPREP: begin
				rneg_q <= num_q[40];
				if (clamp_w) begin
					p_prev_q <= p_cur_q;
					p_cur_q  <= num_q[40] ? -ONE_Q30 : ONE_Q30;
				end
			end
			S_RDIV: begin
				if (div_done) begin
					p_prev_q <= p_cur_q;
					p_cur_q  <= pdiv_w;
				end
			end
			S_TMUL: tprod_q <= tprod_w[63:0];
			S_TRND: term_q  <= round_shr(tprod_q, 2);
			S_OMULC: begin
				c_q <= c_w;
				s_q <= srd_s1;
			end
			S_OABS: begin
				a_q    <= s_q[63] ? (~s_q + 64'd1) : s_q;
				b_q    <= c_q[31] ? 31'(-c_q) : c_q[30:0];
				oneg_q <= s_q[63] ^ c_q[31];
			end
			S_OLO: plo_q <= plo_w;
			S_OHI: phi_q <= phi_w;
			S_OSUM: begin
				out_q.degree <= deg_q;
				out_q.power  <= power_w;
				out_q.last   <= deg_last;
			end
			default: begin
			end
		endcase
	end

	// Particle memories: one write port for loads, one registered read port for the pair walk.
	always_ff @(posedge clk) begin
		if (req_fire && requests.data.action == ACT_LOAD_LEFT && slot_p_ok) begin
			lmem[slot_p] <= {requests.data.dir_x, requests.data.dir_y,
				requests.data.dir_z, requests.data.weight};
		end
		lrd_s1 <= lmem[pi_q[PAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (req_fire && requests.data.action == ACT_LOAD_RIGHT && slot_p_ok) begin
			rmem[slot_p] <= {requests.data.dir_x, requests.data.dir_y,
				requests.data.dir_z, requests.data.weight};
		end
		rrd_s1 <= rmem[pj_q[PAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (req_fire && requests.data.action == ACT_COEFF_LEFT && slot_d_ok) begin
			lcm[slot_d] <= requests.data.coeff;
		end
		lcrd_s1 <= lcm[saddr];
	end

	always_ff @(posedge clk) begin
		if (req_fire && requests.data.action == ACT_COEFF_RIGHT && slot_d_ok) begin
			rcm[slot_d] <= requests.data.coeff;
		end
		rcrd_s1 <= rcm[saddr];
	end

	// Sum memory: cleared in CLEAR, read in TRND, written back in TACC, so the entry never overlaps itself.
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			smem[saddr] <= 64'sd0;
		end else if (state_q == S_TACC) begin
			smem[saddr] <= sat_w;
		end
		srd_s1 <= smem[saddr];
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;
endmodule

[design/plps_checker.sv]
// Port-level checks of the pairwise Legendre power spectrum block, bound to the top level.
module plps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [6:0]  res_degree,
	input logic [63:0] res_power,
	input logic        res_last
);
	import plps_pkg::*;

	// A pending result means a compute is still running, so no request is taken.
	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready)
		else $error("request ready while a result is pending");

	// A stalled result holds its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_degree) &&
		$stable(res_power) && $stable(res_last))
		else $error("stalled result changed");

	// After a result that is not the last, the block stays busy.
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last |=> !req_ready)
		else $error("compute ended before the last result");

	// Degrees start at one.
	a_degree_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_degree != 7'd0)
		else $error("result with degree zero");

	// Each result is computed afresh, so an accepted result is never followed at once by another.
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> !res_valid)
		else $error("result offered in the cycle after an accepted one");
endmodule

bind pairwise_legendre_power_spectrum plps_checker u_plps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (requests.valid),
	.req_ready  (requests.ready),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.res_degree (results.data.degree),
	.res_power  (results.data.power),
	.res_last   (results.data.last)
);
